// File: rtl/core/twr_pkg.sv
// Shared types, codes and constants of the two-way ranging initiator.
// Used by the channel interfaces and by every module under rtl/core.
package twr_pkg;

	localparam int unsigned STAMP_BITS  = 40;
	localparam int unsigned TS_W        = 40;
	localparam int unsigned PAYLOAD_MIN = 14;

	localparam logic [7:0]  CODE_POLL     = 8'hE0;
	localparam logic [7:0]  CODE_RESP     = 8'hE1;
	localparam logic [7:0]  OWN_ID_RESET  = 8'd0;
	localparam logic [23:0] MM_RESET      = 24'd153695;
	localparam logic [15:0] TIMEOUT_RESET = 16'd200;
	localparam logic [15:0] WAIT_MAX      = 16'hFFFF;
	localparam logic [15:0] Q_ROUND       = 16'h8000;

	localparam logic KIND_POLL    = 1'b0;
	localparam logic KIND_OUTCOME = 1'b1;

	typedef enum logic [2:0] {
		CMD_START     = 3'd0,
		CMD_TX_DONE   = 3'd1,
		CMD_RX_BYTE   = 3'd2,
		CMD_FRAME_END = 3'd3,
		CMD_TICK      = 3'd4
	} twr_cmd_t;

	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_TIMEOUT   = 3'd1,
		ST_TOO_SHORT = 3'd2,
		ST_BAD_CODE  = 3'd3,
		ST_MISMATCH  = 3'd4
	} twr_status_t;

	typedef enum logic [1:0] {
		REG_OWN_ID      = 2'd0,
		REG_MM_PER_TICK = 2'd1,
		REG_TIMEOUT     = 2'd2
	} twr_reg_t;

	typedef struct packed {
		logic [2:0]      command;
		logic [7:0]      responder;
		logic [7:0]      rx_byte;
		logic [TS_W-1:0] timestamp;
		logic [6:0]      frame_length;
	} twr_req_t;

	typedef struct packed {
		logic               result_kind;
		logic [7:0]         frame_byte;
		logic               last_byte;
		logic [2:0]         status;
		logic signed [31:0] distance_mm;
	} twr_rsp_t;

	typedef struct packed {
		logic [1:0]  reg_index;
		logic [23:0] data;
	} twr_cfg_wr_t;

	typedef struct packed {
		logic [7:0]  own_id;
		logic [23:0] mm_per_tick_q16;
		logic [15:0] timeout_limit;
	} twr_cfg_t;

	// Per-result control that travels down the pipeline next to the datapath.
	typedef struct packed {
		logic        kind;
		logic [7:0]  frame_byte;
		logic        last_byte;
		twr_status_t status;
		logic        do_dist;
	} twr_meta_t;

endpackage

// File: rtl/core/twr_if.sv
// Valid/ready channel interfaces for requests, results and register writes.
// Depends on twr_pkg for the payload types.
interface twr_req_if;
	logic                valid;
	logic                ready;
	twr_pkg::twr_req_t   payload;
	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

interface twr_rsp_if;
	logic                valid;
	logic                ready;
	twr_pkg::twr_rsp_t   payload;
	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

interface twr_cfg_if;
	logic                valid;
	logic                ready;
	twr_pkg::twr_cfg_wr_t payload;
	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

// File: rtl/core/twr_ctrl.sv
// Ranging control: exchange state, response byte store, poll sequencing.
// Produces the first pipeline stage for twr_dist. Depends on twr_pkg.
module twr_ctrl #(
	parameter int unsigned STAMP_BITS = twr_pkg::STAMP_BITS
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  twr_pkg::twr_cfg_t      cfg_regs,
	input  twr_pkg::twr_req_t      req,
	input  logic                   req_valid,
	output logic                   req_ready,
	input  logic                   adv,
	output logic                   valid_s1,
	output twr_pkg::twr_meta_t     meta_s1,
	output logic [STAMP_BITS-1:0]  rnd_s1,
	output logic [STAMP_BITS-1:0]  rep_s1
);
	localparam int unsigned SB   = STAMP_BITS;
	localparam int unsigned TS_W = twr_pkg::TS_W;
	localparam int unsigned PM   = twr_pkg::PAYLOAD_MIN;

	logic [7:0]      seq_q;
	logic [7:0]      tgt_q;
	logic [SB-1:0]   tx_time_q;
	logic [7:0]      resp_q [PM];
	logic [3:0]      idx_q;
	logic            await_q;
	logic [15:0]     wait_q;
	logic [1:0]      poll_cnt_q;

	logic [7:0]      seq_d;
	logic [7:0]      tgt_d;
	logic [SB-1:0]   tx_time_d;
	logic [3:0]      idx_d;
	logic            await_d;
	logic [15:0]     wait_d;
	logic [1:0]      poll_cnt_d;
	logic            valid_d;
	twr_pkg::twr_meta_t meta_d;

	logic            acc;
	logic            store_byte;
	logic [7:0]      seq_prev;
	logic [15:0]     wait_inc;
	logic [SB-1:0]   t1;
	logic [SB-1:0]   t2;
	logic [SB-1:0]   t3;
	logic [SB-1:0]   t4;
	logic [TS_W+SB-1:0] t2_wide;
	logic [TS_W+SB-1:0] t3_wide;
	logic [TS_W+SB-1:0] t4_wide;
	twr_pkg::twr_status_t check_status;

	assign req_ready = adv && (poll_cnt_q == 2'd0);
	assign acc       = req_valid && req_ready;
	assign seq_prev  = seq_q - 8'd1;
	assign wait_inc  = (wait_q != twr_pkg::WAIT_MAX) ? wait_q + 16'd1 : wait_q;

	// Radio stamps are brought to the ranging modulus, which may be wider or
	// narrower than the 40 bits the radio delivers.
	assign t4_wide = {{SB{1'b0}}, req.timestamp};
	assign t2_wide = {{SB{1'b0}}, resp_q[8], resp_q[7], resp_q[6], resp_q[5], resp_q[4]};
	assign t3_wide = {{SB{1'b0}}, resp_q[13], resp_q[12], resp_q[11], resp_q[10], resp_q[9]};
	assign t4 = t4_wide[SB-1:0];
	assign t2 = t2_wide[SB-1:0];
	assign t3 = t3_wide[SB-1:0];
	assign t1 = tx_time_q;

	assign store_byte = acc && (req.command == twr_pkg::CMD_RX_BYTE) && await_q &&
		(idx_q < 4'(PM));

	always_comb begin
		if (req.frame_length < 7'(PM)) begin
			check_status = twr_pkg::ST_TOO_SHORT;
		end else if (resp_q[0] != twr_pkg::CODE_RESP) begin
			check_status = twr_pkg::ST_BAD_CODE;
		end else if (resp_q[1] != tgt_q || resp_q[2] != cfg_regs.own_id ||
				resp_q[3] != seq_prev) begin
			check_status = twr_pkg::ST_MISMATCH;
		end else begin
			check_status = twr_pkg::ST_OK;
		end
	end

	always_comb begin
		seq_d      = seq_q;
		tgt_d      = tgt_q;
		tx_time_d  = tx_time_q;
		idx_d      = idx_q;
		await_d    = await_q;
		wait_d     = wait_q;
		poll_cnt_d = poll_cnt_q;
		valid_d    = 1'b0;
		meta_d     = '0;
		if (poll_cnt_q != 2'd0) begin
			// Remaining poll bytes follow the code byte while the pipeline advances.
			valid_d         = 1'b1;
			meta_d.kind     = twr_pkg::KIND_POLL;
			poll_cnt_d      = poll_cnt_q - 2'd1;
			case (poll_cnt_q)
				2'd3: begin
					meta_d.frame_byte = cfg_regs.own_id;
				end
				2'd2: begin
					meta_d.frame_byte = tgt_q;
				end
				default: begin
					meta_d.frame_byte = seq_prev;
					meta_d.last_byte  = 1'b1;
				end
			endcase
		end else if (acc) begin
			case (req.command)
				twr_pkg::CMD_START: begin
					valid_d           = 1'b1;
					meta_d.kind       = twr_pkg::KIND_POLL;
					meta_d.frame_byte = twr_pkg::CODE_POLL;
					poll_cnt_d        = 2'd3;
					tgt_d             = req.responder;
					seq_d             = seq_q + 8'd1;
					await_d           = 1'b1;
					idx_d             = 4'd0;
					wait_d            = 16'd0;
				end
				twr_pkg::CMD_TX_DONE: begin
					tx_time_d = t4;
					wait_d    = 16'd0;
				end
				twr_pkg::CMD_RX_BYTE: begin
					if (store_byte) begin
						idx_d = idx_q + 4'd1;
					end
				end
				twr_pkg::CMD_FRAME_END: begin
					if (await_q) begin
						valid_d        = 1'b1;
						meta_d.kind    = twr_pkg::KIND_OUTCOME;
						meta_d.status  = check_status;
						meta_d.do_dist = (check_status == twr_pkg::ST_OK);
						await_d        = 1'b0;
						idx_d          = 4'd0;
					end
				end
				twr_pkg::CMD_TICK: begin
					if (await_q) begin
						wait_d = wait_inc;
						if (wait_inc > cfg_regs.timeout_limit) begin
							valid_d       = 1'b1;
							meta_d.kind   = twr_pkg::KIND_OUTCOME;
							meta_d.status = twr_pkg::ST_TIMEOUT;
							await_d       = 1'b0;
							idx_d         = 4'd0;
						end
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seq_q      <= 8'd0;
			tgt_q      <= 8'd0;
			tx_time_q  <= '0;
			idx_q      <= 4'd0;
			await_q    <= 1'b0;
			wait_q     <= 16'd0;
			poll_cnt_q <= 2'd0;
			valid_s1   <= 1'b0;
		end else if (adv) begin
			seq_q      <= seq_d;
			tgt_q      <= tgt_d;
			tx_time_q  <= tx_time_d;
			idx_q      <= idx_d;
			await_q    <= await_d;
			wait_q     <= wait_d;
			poll_cnt_q <= poll_cnt_d;
			valid_s1   <= valid_d;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			meta_s1 <= meta_d;
			rnd_s1  <= t4 - t1;
			rep_s1  <= t3 - t2;
		end
		if (store_byte) begin
			resp_q[idx_q] <= req.rx_byte;
		end
	end

	a_start_seq: assert property (@(posedge clk) disable iff (!arst_n)
		acc && req.command == twr_pkg::CMD_START |=> poll_cnt_q == 2'd3 && await_q)
		else $error("start did not arm the poll sequence");

	a_end_outcome: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(await_q) |-> valid_s1 && meta_s1.kind == twr_pkg::KIND_OUTCOME)
		else $error("exchange closed without an outcome");

	a_poll_bytes: assert property (@(posedge clk) disable iff (!arst_n)
		poll_cnt_q != 2'd0 && adv |=> valid_s1 && meta_s1.kind == twr_pkg::KIND_POLL)
		else $error("pending poll byte was not issued");

endmodule

// File: rtl/core/twr_dist.sv
// Distance datapath: round-trip difference, magnitude, split multiply,
// rounding and saturation, plus result formatting. Depends on twr_pkg.
module twr_dist #(
	parameter int unsigned STAMP_BITS = twr_pkg::STAMP_BITS
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   adv,
	input  logic [23:0]            mm_per_tick_q16,
	input  logic                   valid_s1,
	input  twr_pkg::twr_meta_t     meta_s1,
	input  logic [STAMP_BITS-1:0]  rnd_s1,
	input  logic [STAMP_BITS-1:0]  rep_s1,
	output logic                   valid_s5,
	output twr_pkg::twr_rsp_t      rsp
);
	localparam int unsigned SB = STAMP_BITS;
	localparam int unsigned HW = SB - 16;
	localparam int unsigned PW = HW + 24;
	localparam int unsigned RW = PW + 1;
	localparam logic [RW-1:0] NEG_LIM = RW'(64'h8000_0000);
	localparam logic [RW-1:0] POS_LIM = RW'(64'h7FFF_FFFF);

	logic               valid_s2;
	logic               valid_s3;
	logic               valid_s4;
	twr_pkg::twr_meta_t meta_s2;
	twr_pkg::twr_meta_t meta_s3;
	twr_pkg::twr_meta_t meta_s4;
	twr_pkg::twr_meta_t meta_s5;
	logic [SB-1:0]      d_s2;
	logic [SB-1:0]      mag_s3;
	logic               neg_s3;
	logic               neg_s4;
	logic               neg_s5;
	logic [PW-1:0]      ph_s4;
	logic [39:0]        pl_s4;
	logic [RW-1:0]      r_s5;
	logic [RW-1:0]      r_sat;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
			valid_s5 <= valid_s4;
		end
	end

	// The product is split at bit 16 of the magnitude so that each multiply
	// stays narrow; only the low partial product contributes rounding.
	always_ff @(posedge clk) begin
		if (adv) begin
			meta_s2 <= meta_s1;
			meta_s3 <= meta_s2;
			meta_s4 <= meta_s3;
			meta_s5 <= meta_s4;
			d_s2    <= rnd_s1 - rep_s1;
			neg_s3  <= d_s2[SB-1];
			mag_s3  <= d_s2[SB-1] ? (SB'(0) - d_s2) : d_s2;
			neg_s4  <= neg_s3;
			ph_s4   <= PW'(mag_s3[SB-1:16]) * PW'(mm_per_tick_q16);
			pl_s4   <= 40'(mag_s3[15:0]) * 40'(mm_per_tick_q16);
			neg_s5  <= neg_s4;
			r_s5    <= RW'(ph_s4) + RW'((pl_s4 + 40'(twr_pkg::Q_ROUND)) >> 16);
		end
	end

	always_comb begin
		if (neg_s5) begin
			r_sat = (r_s5 > NEG_LIM) ? NEG_LIM : r_s5;
		end else begin
			r_sat = (r_s5 > POS_LIM) ? POS_LIM : r_s5;
		end
	end

	always_comb begin
		rsp.result_kind = meta_s5.kind;
		rsp.frame_byte  = meta_s5.frame_byte;
		rsp.last_byte   = meta_s5.last_byte;
		rsp.status      = meta_s5.status;
		if (!meta_s5.do_dist) begin
			rsp.distance_mm = 32'sd0;
		end else if (neg_s5) begin
			rsp.distance_mm = $signed(32'd0 - r_sat[31:0]);
		end else begin
			rsp.distance_mm = $signed(r_sat[31:0]);
		end
	end

endmodule

// File: rtl/core/twr_initiator_ranging.sv
// Initiator of single-sided two-way ranging. An accepted item is registered in s1 and
// passes s2 to s5 to the output register. The whole pipeline holds while a result waits
// to be taken. Throughput: one item per cycle while the pipeline advances; after a start,
// no request is taken until its four poll bytes have entered the pipeline.
// Reset clears all control state and loads register defaults; response bytes are not reset.
module twr_initiator_ranging #(
	parameter int unsigned STAMP_BITS = twr_pkg::STAMP_BITS
) (
	input logic          clk,
	input logic          arst_n,
	twr_req_if.sink      request,
	twr_rsp_if.source    result,
	twr_cfg_if.sink      cfg
);
	twr_pkg::twr_cfg_t       cfg_q;
	twr_pkg::twr_meta_t      meta_s1;
	twr_pkg::twr_rsp_t       rsp_s5;
	twr_pkg::twr_rsp_t       out_q;
	logic                    out_valid_q;
	logic                    adv;
	logic                    valid_s1;
	logic                    valid_s5;
	logic [STAMP_BITS-1:0]   rnd_s1;
	logic [STAMP_BITS-1:0]   rep_s1;

	assign adv            = !out_valid_q || result.ready;
	assign cfg.ready      = 1'b1;
	assign result.valid   = out_valid_q;
	assign result.payload = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.own_id          <= twr_pkg::OWN_ID_RESET;
			cfg_q.mm_per_tick_q16 <= twr_pkg::MM_RESET;
			cfg_q.timeout_limit   <= twr_pkg::TIMEOUT_RESET;
		end else if (cfg.valid) begin
			case (cfg.payload.reg_index)
				twr_pkg::REG_OWN_ID: begin
					cfg_q.own_id <= cfg.payload.data[7:0];
				end
				twr_pkg::REG_MM_PER_TICK: begin
					cfg_q.mm_per_tick_q16 <= cfg.payload.data;
				end
				twr_pkg::REG_TIMEOUT: begin
					cfg_q.timeout_limit <= cfg.payload.data[15:0];
				end
				default: begin
				end
			endcase
		end
	end

	twr_ctrl #(
		.STAMP_BITS (STAMP_BITS)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_regs  (cfg_q),
		.req       (request.payload),
		.req_valid (request.valid),
		.req_ready (request.ready),
		.adv       (adv),
		.valid_s1  (valid_s1),
		.meta_s1   (meta_s1),
		.rnd_s1    (rnd_s1),
		.rep_s1    (rep_s1)
	);

	twr_dist #(
		.STAMP_BITS (STAMP_BITS)
	) u_dist (
		.clk             (clk),
		.arst_n          (arst_n),
		.adv             (adv),
		.mm_per_tick_q16 (cfg_q.mm_per_tick_q16),
		.valid_s1        (valid_s1),
		.meta_s1         (meta_s1),
		.rnd_s1          (rnd_s1),
		.rep_s1          (rep_s1),
		.valid_s5        (valid_s5),
		.rsp             (rsp_s5)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= valid_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_q <= rsp_s5;
		end
	end

endmodule
